### src/assert_macros.svh
// Assertion macros used by the top level of the list engine RTL.
// Depends on a clock named aclk and an active-low reset named aresetn in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while the block is out of reset.
`define BALE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Checked on every clock edge, reset included.
`define BALE_ASSERT_ANY(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error(msg);

`endif

### src/bale_pkg.sv
// Shared constants and types of the bounded array list engine.
// No dependencies; imported by the cell and the top level.
`timescale 1ns / 1ps
`default_nettype none

package bale_pkg;

    localparam int CMD_W = 3;
    localparam int POS_W = 7;
    localparam int CAP_W = 7;
    localparam int VAL_W = 32;
    localparam int IN_DATA_W = 40;
    localparam int OUT_DATA_W = 56;

    localparam logic [CMD_W-1:0] CMD_INSERT  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SEARCH  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SELECT  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_REPLACE = 3'd4;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    typedef struct packed {
        logic load;
        logic take_left;
        logic take_right;
        logic live;
        logic read_en;
    } cell_ctrl_t;

endpackage

`default_nettype wire

### src/bale_cell.sv
// One storage cell of the list chain: holds a single entry and trades it with its neighbors.
// Depends on bale_pkg for the cell control struct.
`timescale 1ns / 1ps
`default_nettype none

module bale_cell
    import bale_pkg::*;
#(
    parameter int WORD_WIDTH = 32
) (
    input  wire logic                  aclk,
    input  wire cell_ctrl_t            ctrl,
    input  wire logic [WORD_WIDTH-1:0] left_data,
    input  wire logic [WORD_WIDTH-1:0] right_data,
    input  wire logic [WORD_WIDTH-1:0] load_data,
    input  wire logic [WORD_WIDTH-1:0] key,
    output logic      [WORD_WIDTH-1:0] data,
    output logic                       match,
    output logic      [WORD_WIDTH-1:0] rd_data
);

    logic [WORD_WIDTH-1:0] data_reg;
    logic [WORD_WIDTH-1:0] data_next;

    always_comb begin
        data_next = data_reg;
        if (ctrl.load) begin
            data_next = load_data;
        end else if (ctrl.take_left) begin
            data_next = left_data;
        end else if (ctrl.take_right) begin
            data_next = right_data;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data    = data_reg;
    assign match   = ctrl.live && (data_reg == key);
    assign rd_data = ctrl.read_en ? data_reg : '0;

endmodule

`default_nettype wire

### src/bale_prienc.sv
// Priority encoder over the registered match flags of the cell chain.
// Standalone; instantiated by the top level.
`timescale 1ns / 1ps
`default_nettype none

module bale_prienc #(
    parameter int DEPTH = 64
) (
    input  wire logic [DEPTH-1:0]         match,
    output logic                          hit,
    output logic      [$clog2(DEPTH)-1:0] idx
);

    localparam int IDX_W = $clog2(DEPTH);

    always_comb begin
        hit = |match;
        idx = '0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (match[i]) begin
                idx = IDX_W'(i);
            end
        end
    end

endmodule

`default_nettype wire

### src/bounded_array_list_engine_unit.sv
// Bounded array list engine: an ordered list of up to DEPTH words kept packed from position 0,
// driven by insert, remove, search, select and replace commands, one result item per command.
// A command passes through the sequencer states ST_IDLE, in which it is accepted, ST_EXEC, in
// which every cell of the chain shifts, loads or compares in parallel, and ST_FIN, in which the
// first match is encoded and the result register loads once the output is empty or being read.
// The sequencer handles one command at a time, so a new item is taken only after the result of
// the last one is loaded, and a waiting result holds off the input.
// Depends on bale_pkg, bale_cell, bale_prienc and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module bounded_array_list_engine_unit
    import bale_pkg::*;
#(
    parameter int DEPTH      = 64,
    parameter int WORD_WIDTH = 32
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CAP_W-1:0]      cfg_wdata,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,  // position[6:0], value[38:7], zero pad
    input  wire logic [CMD_W-1:0]      s_tuser,  // cmd[2:0]
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [OUT_DATA_W-1:0] m_tdata   // ok[0], found_position[7:1],
                                                 // read_value[39:8], entry_count[46:40],
                                                 // is_empty[47], is_full[48], zero pad
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0]            state_reg;
    logic [1:0]            state_next;
    logic [CMD_W-1:0]      cmd_reg;
    logic [POS_W-1:0]      pos_reg;
    logic [WORD_WIDTH-1:0] val_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic [CAP_W-1:0]      cap_reg;
    logic                  ok_reg;
    logic                  ok_next;
    logic                  srch_reg;
    logic [DEPTH-1:0]      match_reg;
    logic [WORD_WIDTH-1:0] rd_reg;
    logic                  m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;

    logic                  do_ins;
    logic                  do_rem;
    logic                  do_rep;
    logic                  do_sel;
    logic                  is_srch;
    logic                  full;
    logic [CMP_W-1:0]      pos_c;
    logic [CMP_W-1:0]      cnt_c;
    logic [CMP_W-1:0]      sel_c;
    logic                  load_out;
    logic                  hit;
    logic [IDX_W-1:0]      hit_idx;
    logic [CNT_W-1:0]      found_full;
    logic                  ok_out;
    logic [WORD_WIDTH-1:0] rd_or;

    cell_ctrl_t            cell_ctrl [DEPTH];
    logic [WORD_WIDTH-1:0] cell_data [DEPTH];
    logic [WORD_WIDTH-1:0] cell_rd   [DEPTH];
    logic [DEPTH-1:0]      match_vec;

    assign s_tready = (state_reg == ST_IDLE);
    assign pos_c    = CMP_W'(pos_reg);
    assign cnt_c    = CMP_W'(count_reg);
    assign full     = (cnt_c >= CMP_W'(cap_reg)) || (count_reg >= CNT_W'(DEPTH));
    assign sel_c    = (pos_c < cnt_c) ? pos_c : (cnt_c - CMP_W'(1));

    always_comb begin
        do_ins  = 1'b0;
        do_rem  = 1'b0;
        do_rep  = 1'b0;
        do_sel  = 1'b0;
        is_srch = 1'b0;
        if (state_reg == ST_EXEC) begin
            unique case (cmd_reg)
                CMD_INSERT:  do_ins  = !full && (pos_c <= cnt_c);
                CMD_REMOVE:  do_rem  = pos_c < cnt_c;
                CMD_SEARCH:  is_srch = 1'b1;
                CMD_SELECT:  do_sel  = count_reg != '0;
                CMD_REPLACE: do_rep  = pos_c < cnt_c;
                default:     is_srch = 1'b0;
            endcase
        end
    end

    always_comb begin
        count_next = count_reg;
        if (do_ins) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_rem) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    assign ok_next = do_ins || do_rem || do_rep || do_sel;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [WORD_WIDTH-1:0] left_d;
        logic [WORD_WIDTH-1:0] right_d;

        if (i == 0) begin : g_first
            assign left_d = '0;
        end else begin : g_inner_l
            assign left_d = cell_data[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign right_d = '0;
        end else begin : g_inner_r
            assign right_d = cell_data[i+1];
        end

        assign cell_ctrl[i].load       = (do_ins || do_rep) && (CMP_W'(i) == pos_c);
        assign cell_ctrl[i].take_left  = do_ins && (CMP_W'(i) > pos_c) && (CMP_W'(i) <= cnt_c);
        assign cell_ctrl[i].take_right = do_rem && (CMP_W'(i) >= pos_c)
                                         && (CMP_W'(i + 1) < cnt_c);
        assign cell_ctrl[i].live       = CMP_W'(i) < cnt_c;
        assign cell_ctrl[i].read_en    = do_sel && (CMP_W'(i) == sel_c);

        bale_cell #(
            .WORD_WIDTH (WORD_WIDTH)
        ) u_cell (
            .aclk       (aclk),
            .ctrl       (cell_ctrl[i]),
            .left_data  (left_d),
            .right_data (right_d),
            .load_data  (val_reg),
            .key        (val_reg),
            .data       (cell_data[i]),
            .match      (match_vec[i]),
            .rd_data    (cell_rd[i])
        );
    end

    always_comb begin
        rd_or = '0;
        for (int i = 0; i < DEPTH; i++) begin
            rd_or = rd_or | cell_rd[i];
        end
    end

    bale_prienc #(
        .DEPTH (DEPTH)
    ) u_prienc (
        .match (match_reg),
        .hit   (hit),
        .idx   (hit_idx)
    );

    assign found_full = srch_reg ? (hit ? CNT_W'(hit_idx) : count_reg) : '0;
    assign ok_out     = srch_reg ? hit : ok_reg;
    assign load_out   = (state_reg == ST_FIN) && (!m_tvalid_reg || m_tready);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: state_next = ST_FIN;
            ST_FIN: begin
                if (load_out) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            cap_reg      <= CAP_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_EXEC) begin
                count_reg <= count_next;
            end
            if (cfg_we) begin
                cap_reg <= cfg_wdata;
            end
            if (load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            cmd_reg <= s_tuser;
            pos_reg <= s_tdata[POS_W-1:0];
            val_reg <= WORD_WIDTH'(s_tdata[POS_W +: VAL_W]);
        end
        if (state_reg == ST_EXEC) begin
            ok_reg    <= ok_next;
            srch_reg  <= is_srch;
            match_reg <= match_vec;
            rd_reg    <= rd_or;
        end
        if (load_out) begin
            m_tdata_reg <= {
                (OUT_DATA_W - 49)'(0),
                full,
                count_reg == '0,
                POS_W'(count_reg),
                VAL_W'(rd_reg),
                POS_W'(found_full),
                ok_out
            };
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `BALE_ASSERT(a_count_bound, count_reg <= CNT_W'(DEPTH), "entry count exceeds depth")
    `BALE_ASSERT(a_accept_exec, s_tvalid && s_tready |=> state_reg == ST_EXEC,
                 "accepted item did not start execution")
    `BALE_ASSERT(a_count_hold, state_reg != ST_EXEC |=> $stable(count_reg),
                 "entry count changed outside execution")
    `BALE_ASSERT_ANY(a_reset_idle, !aresetn |=> state_reg == ST_IDLE && !m_tvalid_reg,
                     "reset did not clear sequencer and output")

endmodule

`default_nettype wire
